FILE: design/smx_pkg.sv
// Shared types and constants for the stack machine execute unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package smx_pkg;

  // Default sizes, overridable on the top level
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned PROG_SIZE_DEF   = 256;

  // Field widths fixed by the instruction format
  localparam int unsigned ACTION_W  = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned NEXT_PC_W = 8;

  // Opcodes
  typedef enum logic [ACTION_W-1:0] {
    OP_ADD    = 4'd0,
    OP_READ   = 4'd1,
    OP_WRITE  = 4'd2,
    OP_PUSH   = 4'd3,
    OP_DUP    = 4'd4,
    OP_JUMPIF = 4'd5,
    OP_MUL    = 4'd6,
    OP_SWAP   = 4'd7,
    OP_OVER   = 4'd8
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNDER = 2'd1,
    ST_OVER  = 2'd2
  } status_e;

  // What a stack cell loads on the next edge
  typedef enum logic [1:0] {
    SEL_HOLD = 2'd0,
    SEL_UP   = 2'd1,
    SEL_DOWN = 2'd2
  } cell_sel_e;

  // Input word: one instruction
  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] operand;
  } smx_in_t;

  // Result word
  typedef struct packed {
    logic [NEXT_PC_W-1:0]     next_pc;
    logic                     write_valid;
    logic signed [DATA_W-1:0] write_value;
    logic [1:0]               status;
  } smx_out_t;

endpackage

`default_nettype wire

FILE: design/smx_cell.sv
// One stack cell: holds a single 32-bit entry and takes its neighbor's value.
// Depends on smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smx_cell (
  input  logic                        clk_i,
  input  smx_pkg::cell_sel_e          sel_i,
  input  logic [smx_pkg::DATA_W-1:0]  up_val_i,
  input  logic [smx_pkg::DATA_W-1:0]  down_val_i,
  output logic [smx_pkg::DATA_W-1:0]  val_o
);
  import smx_pkg::*;

  logic [DATA_W-1:0] val_q;
  logic [DATA_W-1:0] val_d;

  // Entry mux: hold, take the cell above (push side) or below (pop side)
  always_comb begin
    case (sel_i)
      SEL_UP:   val_d = up_val_i;
      SEL_DOWN: val_d = down_val_i;
      default:  val_d = val_q;
    endcase
  end

  // Payload only, no reset
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

FILE: design/smx_target.sv
// Jump target reduction: operand modulo PROG_SIZE from a precomputed
// quotient estimate. Depends on smx_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smx_target #(
  parameter int unsigned PROG_SIZE = smx_pkg::PROG_SIZE_DEF,
  localparam int unsigned PC_W = (PROG_SIZE > 1) ? $clog2(PROG_SIZE) : 1
) (
  input  logic [smx_pkg::DATA_W-1:0] operand_i,
  input  logic [smx_pkg::DATA_W-1:0] quot_i,
  output logic [PC_W-1:0]            target_o
);
  import smx_pkg::*;

  // Quotient estimate is at most one low, so the raw remainder is below 2*PROG_SIZE;
  // two spare bits keep the narrow arithmetic exact.
  localparam int unsigned R_W = PC_W + 2;
  localparam logic [R_W-1:0] DIV = R_W'(PROG_SIZE);

  logic [R_W-1:0] prod;
  logic [R_W-1:0] rem0;
  logic [R_W-1:0] rem1;
  logic [R_W-1:0] rem2;

  // Only the low bits of x - q*d matter
  assign prod = quot_i[R_W-1:0] * DIV;
  assign rem0 = operand_i[R_W-1:0] - prod;

  // Correction steps
  assign rem1 = (rem0 >= DIV) ? rem0 - DIV : rem0;
  assign rem2 = (rem1 >= DIV) ? rem1 - DIV : rem1;

  assign target_o = rem2[PC_W-1:0];

endmodule

`default_nettype wire

FILE: design/stack_machine_execute_unit.sv
// Top level of the stack machine execute unit: input register, stack cell
// chain, ALU and result register. Depends on smx_pkg, smx_cell, smx_target.
`timescale 1ns / 1ps
`default_nettype none

// One instruction is taken per clock whenever start is high; busy stays low,
// so instructions may follow each other back to back. The result word for an
// instruction appears on result_o with done_o high once the result register
// has taken it, for one cycle only, and must be captured at the edge that ends
// that cycle. The input register takes the instruction and a quotient estimate
// for the jump target; the execute stage then runs it against the stack. The
// stack is a chain of STACK_DEPTH cells that shift as a whole on push and pop,
// so every opcode, including mul, finishes in the execute stage. Stack
// contents are not cleared by reset; only the entry count, counter and valid
// flags are.
module stack_machine_execute_unit #(
  parameter int unsigned STACK_DEPTH = smx_pkg::STACK_DEPTH_DEF,
  parameter int unsigned PROG_SIZE   = smx_pkg::PROG_SIZE_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  smx_pkg::smx_in_t  word_i,
  output logic              done_o,
  output smx_pkg::smx_out_t result_o
);
  import smx_pkg::*;

  localparam int unsigned PC_W  = (PROG_SIZE > 1) ? $clog2(PROG_SIZE) : 1;
  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam logic [63:0] RECIP_W = 64'h1_0000_0000 / 64'(PROG_SIZE);
  localparam logic [DATA_W-1:0] RECIP = RECIP_W[DATA_W-1:0];
  localparam logic [CNT_W-1:0] DEPTH = CNT_W'(STACK_DEPTH);
  localparam logic [PC_W-1:0]  PC_LAST = PC_W'(PROG_SIZE - 1);

  // Stage 1: registered instruction
  logic                s1_valid_q;
  logic [ACTION_W-1:0] s1_action_q;
  logic [DATA_W-1:0]   s1_operand_q;
  logic [DATA_W-1:0]   s1_quot_q;
  logic [2*DATA_W-1:0] quot_full;

  // Architectural state
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PC_W-1:0]  pc_q, pc_d;

  // Execute signals
  logic [1:0]        pops;
  logic              grow;
  logic              err_under, err_over;
  logic [DATA_W-1:0] top_a, top_b;
  logic [DATA_W-1:0] sum, prod;
  logic [DATA_W-1:0] inject;
  logic [PC_W-1:0]   pc_inc, target;
  cell_sel_e         sel_top, sel_second, sel_rest;
  logic [DATA_W-1:0] cell_val [STACK_DEPTH];

  // Result register
  logic     done_q;
  smx_out_t res_q, res_d;

  // Instruction accepted every cycle
  assign busy = 1'b0;

  // Quotient estimate for the jump target: floor(x * floor(2^32/P) / 2^32)
  assign quot_full = {{DATA_W{1'b0}}, word_i.operand} * {{DATA_W{1'b0}}, RECIP};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_action_q  <= word_i.action;
      s1_operand_q <= word_i.operand;
      s1_quot_q    <= quot_full[2*DATA_W-1:DATA_W];
    end
  end

  // Jump target reduction
  smx_target #(
    .PROG_SIZE (PROG_SIZE)
  ) u_target (
    .operand_i (s1_operand_q),
    .quot_i    (s1_quot_q),
    .target_o  (target)
  );

  // Stack cell chain; cell 0 is the top of stack
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    cell_sel_e         sel;
    logic [DATA_W-1:0] up_val;
    logic [DATA_W-1:0] down_val;

    assign sel = (i == 0) ? sel_top : ((i == 1) ? sel_second : sel_rest);

    if (i == 0) begin : g_first
      assign up_val = inject;
    end else begin : g_mid
      assign up_val = cell_val[i-1];
    end

    if (i == STACK_DEPTH - 1) begin : g_last
      assign down_val = '0;
    end else begin : g_inner
      assign down_val = cell_val[i+1];
    end

    smx_cell u_cell (
      .clk_i      (clk_i),
      .sel_i      (sel),
      .up_val_i   (up_val),
      .down_val_i (down_val),
      .val_o      (cell_val[i])
    );
  end

  // ALU on the two top entries
  assign top_a  = cell_val[0];
  assign top_b  = cell_val[1];
  assign sum    = top_a + top_b;
  assign prod   = top_a * top_b;
  assign pc_inc = (pc_q == PC_LAST) ? '0 : pc_q + 1'b1;

  // Stack effect of each opcode
  always_comb begin
    pops = 2'd0;
    grow = 1'b0;
    case (s1_action_q)
      OP_ADD, OP_MUL, OP_SWAP: pops = 2'd2;
      OP_OVER: begin
        pops = 2'd2;
        grow = 1'b1;
      end
      OP_WRITE, OP_JUMPIF: pops = 2'd1;
      OP_DUP: begin
        pops = 2'd1;
        grow = 1'b1;
      end
      OP_READ, OP_PUSH: grow = 1'b1;
      default: ;
    endcase
  end

  assign err_under = cnt_q < CNT_W'(pops);
  assign err_over  = !err_under && grow && (cnt_q == DEPTH);

  // Execute: cell selects, new count and counter, result word
  always_comb begin
    sel_top    = SEL_HOLD;
    sel_second = SEL_HOLD;
    sel_rest   = SEL_HOLD;
    inject     = s1_operand_q;
    cnt_d      = cnt_q;
    pc_d       = pc_q;
    res_d      = '0;

    if (err_under) begin
      res_d.status = ST_UNDER;
    end else if (err_over) begin
      res_d.status = ST_OVER;
    end else begin
      res_d.status = ST_OK;
      pc_d         = pc_inc;
      case (s1_action_q)
        OP_ADD, OP_MUL: begin
          inject     = (s1_action_q == OP_ADD) ? sum : prod;
          sel_top    = SEL_UP;
          sel_second = SEL_DOWN;
          sel_rest   = SEL_DOWN;
          cnt_d      = cnt_q - 1'b1;
        end
        OP_READ, OP_PUSH, OP_DUP, OP_OVER: begin
          if (s1_action_q == OP_DUP) begin
            inject = top_a;
          end else if (s1_action_q == OP_OVER) begin
            inject = top_b;
          end
          sel_top    = SEL_UP;
          sel_second = SEL_UP;
          sel_rest   = SEL_UP;
          cnt_d      = cnt_q + 1'b1;
        end
        OP_WRITE, OP_JUMPIF: begin
          sel_top    = SEL_DOWN;
          sel_second = SEL_DOWN;
          sel_rest   = SEL_DOWN;
          cnt_d      = cnt_q - 1'b1;
          if (s1_action_q == OP_WRITE) begin
            res_d.write_valid = 1'b1;
            res_d.write_value = top_a;
          end else if (!top_a[DATA_W-1]) begin
            pc_d = target;
          end
        end
        OP_SWAP: begin
          inject     = top_b;
          sel_top    = SEL_UP;
          sel_second = SEL_UP;
        end
        default: ;
      endcase
    end
    res_d.next_pc = NEXT_PC_W'(pc_d);

    // Nothing moves without an instruction in the execute stage
    if (!s1_valid_q) begin
      sel_top    = SEL_HOLD;
      sel_second = SEL_HOLD;
      sel_rest   = SEL_HOLD;
      cnt_d      = cnt_q;
      pc_d       = pc_q;
    end
  end

  // State and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      pc_q   <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      pc_q   <= pc_d;
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

FILE: design/smx_checker.sv
// Port-level checks for the stack machine execute unit, bound to the top.
// Depends on smx_pkg and stack_machine_execute_unit.
`timescale 1ns / 1ps
`default_nettype none

module smx_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              busy,
  input  smx_pkg::smx_in_t  word_i,
  input  logic              done_o,
  input  smx_pkg::smx_out_t result_o
);
  import smx_pkg::*;

  // A result only follows an instruction that passed through the input and result registers
  a_done_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 2))
    else $error("result without a matching instruction");

  // Only a successful write emits a value
  a_write_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.write_valid ==
                ($past(word_i.action, 2) == OP_WRITE && result_o.status == ST_OK)))
    else $error("write_valid does not match the instruction");

  // A failed instruction reports no value
  a_err_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != ST_OK) |->
      (!result_o.write_valid && result_o.write_value == '0))
    else $error("value reported on a stack error");

  // A failed instruction right after another leaves the counter where that one put it
  a_err_pc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(done_o) && result_o.status != ST_OK) |->
      (result_o.next_pc == $past(result_o.next_pc)))
    else $error("counter moved on a stack error");

endmodule

bind stack_machine_execute_unit smx_checker u_smx_checker (.*);

`default_nettype wire
